[design/rchf_pkg.sv]
package rchf_pkg;

    localparam int MAP_SIDE      = 640;
    localparam int REACH         = 319;
    localparam int TAN_FRAC_BITS = 16;

    localparam int COORD_W   = 10;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 3 * CHAN_W;
    localparam int ANGLE_W   = 9;
    localparam int CFG_IDX_W = 2;

    localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W    = $clog2(MAP_CELLS);
    localparam int STEP_W    = $clog2(REACH + 2) + 2;
    localparam int POS_W     = $clog2(2 * REACH + 2) + 2;
    localparam int ACC_W     = $clog2(REACH + 2) + TAN_FRAC_BITS + 2;
    localparam int TAN_W     = TAN_FRAC_BITS + 2;

    localparam logic signed [STEP_W-1:0] REACH_S = STEP_W'(REACH);
    localparam logic signed [POS_W-1:0]  REACH_P = POS_W'(REACH);
    localparam logic signed [ACC_W-1:0]  ACC_BOUND =
        ACC_W'(longint'(REACH + 1) << TAN_FRAC_BITS);

    localparam int ANG_OFFSET  = 45;
    localparam int ANG_QUARTER = 90;
    localparam int ANG_FULL    = 360;
    localparam int ANG_SUM_W   = ANGLE_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COLOR_W-1:0] COLOR_ONE_RESET = {8'd244, 8'd240, 8'd226};
    localparam logic [COLOR_W-1:0] COLOR_TWO_RESET = {8'd244, 8'd243, 8'd236};

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ONE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_TWO = CFG_IDX_W'(1);

    localparam int TAN_ENTRIES = 46;
    localparam int TAN_IDX_W   = $clog2(TAN_ENTRIES);
    localparam int TAN_LSHIFT  = (TAN_FRAC_BITS >= 16) ? TAN_FRAC_BITS - 16 : 0;
    localparam int TAN_RSHIFT  = (TAN_FRAC_BITS < 16) ? 16 - TAN_FRAC_BITS : 0;
    localparam int TAN_WIDE_W  = 17 + TAN_LSHIFT;

    localparam logic [16:0] TAN_Q16 [TAN_ENTRIES] = '{
        17'd0,     17'd1144,  17'd2289,  17'd3435,  17'd4583,  17'd5734,
        17'd6888,  17'd8047,  17'd9210,  17'd10380, 17'd11556, 17'd12739,
        17'd13930, 17'd15130, 17'd16340, 17'd17560, 17'd18792, 17'd20036,
        17'd21294, 17'd22566, 17'd23853, 17'd25157, 17'd26478, 17'd27818,
        17'd29179, 17'd30560, 17'd31964, 17'd33392, 17'd34846, 17'd36327,
        17'd37837, 17'd39378, 17'd40951, 17'd42560, 17'd44205, 17'd45889,
        17'd47615, 17'd49385, 17'd51202, 17'd53070, 17'd54991, 17'd56970,
        17'd59009, 17'd61113, 17'd63287, 17'd65536
    };

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_CAST  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        PCLS_NONE = 2'd0,
        PCLS_ONE  = 2'd1,
        PCLS_TWO  = 2'd2
    } pix_class_t;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_MARCH
    } bk_state_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [ADDR_W-1:0]        addr;
        pix_class_t               pcls;
        logic                     step_neg;
        logic                     major_is_col;
        logic signed [TAN_W-1:0]  slope;
    } job_t;

    function automatic logic [TAN_W-2:0] tan_mag(input logic [TAN_IDX_W-1:0] idx);
        logic [TAN_WIDE_W-1:0] wide;
        wide = TAN_WIDE_W'(TAN_Q16[idx]) << TAN_LSHIFT;
        wide = wide >> TAN_RSHIFT;
        return wide[TAN_W-2:0];
    endfunction

endpackage

[design/rchf_ifs.sv]
interface rchf_item_if
    import rchf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               command;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [ANGLE_W-1:0] angle_deg;

    modport source (
        output valid, command, pixel_col, pixel_row, blue, green, red, angle_deg,
        input  ready
    );
    modport sink (
        input  valid, command, pixel_col, pixel_row, blue, green, red, angle_deg,
        output ready
    );
endinterface

interface rchf_result_if
    import rchf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] hit_col;
    logic [COORD_W-1:0] hit_row;
    logic               blocked;

    modport source (
        output valid, hit_col, hit_row, blocked,
        input  ready
    );
    modport sink (
        input  valid, hit_col, hit_row, blocked,
        output ready
    );
endinterface

interface rchf_cfg_if
    import rchf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[design/rchf_front.sv]
module rchf_front
    import rchf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rchf_item_if.sink    item,
    rchf_cfg_if.sink     cfg,
    output logic         push_valid,
    input  logic         push_ready,
    output job_t         push_job
);

    logic [COLOR_W-1:0]      color_one_reg;
    logic [COLOR_W-1:0]      color_one_next;
    logic [COLOR_W-1:0]      color_two_reg;
    logic [COLOR_W-1:0]      color_two_next;
    logic [COLOR_W-1:0]      pix_color;
    logic                    on_map;
    logic [ANG_SUM_W-1:0]    ang_sum;
    logic [ANG_SUM_W-1:0]    ang_wrap;
    logic [ANG_SUM_W-1:0]    rem;
    logic                    step_neg;
    logic                    major_is_col;
    logic                    phase_neg;
    logic [TAN_IDX_W-1:0]    tan_idx;
    logic signed [TAN_W-1:0] slope_pos;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        color_one_next = color_one_reg;
        color_two_next = color_two_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_COLOR_ONE: color_one_next = cfg.data;
                REG_COLOR_TWO: color_two_next = cfg.data;
                default:       color_one_next = color_one_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_one_reg <= COLOR_ONE_RESET;
            color_two_reg <= COLOR_TWO_RESET;
        end
        else
        begin
            color_one_reg <= color_one_next;
            color_two_reg <= color_two_next;
        end
    end

    // quadrant and phase of the ray
    always_comb
    begin
        ang_sum  = ANG_SUM_W'(item.angle_deg) + ANG_SUM_W'(ANG_OFFSET);
        ang_wrap = (ang_sum >= ANG_SUM_W'(ANG_FULL)) ?
                   ang_sum - ANG_SUM_W'(ANG_FULL) : ang_sum;
        priority if (ang_wrap < ANG_SUM_W'(ANG_QUARTER))
        begin
            step_neg     = 1'b0;
            major_is_col = 1'b0;
            rem          = ang_wrap;
        end
        else if (ang_wrap < ANG_SUM_W'(2 * ANG_QUARTER))
        begin
            step_neg     = 1'b0;
            major_is_col = 1'b1;
            rem          = ang_wrap - ANG_SUM_W'(ANG_QUARTER);
        end
        else if (ang_wrap < ANG_SUM_W'(3 * ANG_QUARTER))
        begin
            step_neg     = 1'b1;
            major_is_col = 1'b0;
            rem          = ang_wrap - ANG_SUM_W'(2 * ANG_QUARTER);
        end
        else
        begin
            step_neg     = 1'b1;
            major_is_col = 1'b1;
            rem          = ang_wrap - ANG_SUM_W'(3 * ANG_QUARTER);
        end
        phase_neg = rem > ANG_SUM_W'(ANG_OFFSET);
        tan_idx   = phase_neg ? TAN_IDX_W'(rem - ANG_SUM_W'(ANG_OFFSET)) :
                                TAN_IDX_W'(ANG_SUM_W'(ANG_OFFSET) - rem);
        slope_pos = TAN_W'(tan_mag(tan_idx));
    end

    assign pix_color = {item.red, item.green, item.blue};
    assign on_map    = (32'(item.pixel_col) < MAP_SIDE) && (32'(item.pixel_row) < MAP_SIDE);

    always_comb
    begin
        push_job.cmd          = cmd_t'(item.command);
        push_job.addr         = ADDR_W'(item.pixel_row) * ADDR_W'(MAP_SIDE) +
                                ADDR_W'(item.pixel_col);
        priority if (pix_color == color_one_reg)
        begin
            push_job.pcls = PCLS_ONE;
        end
        else if (pix_color == color_two_reg)
        begin
            push_job.pcls = PCLS_TWO;
        end
        else
        begin
            push_job.pcls = PCLS_NONE;
        end
        push_job.step_neg     = step_neg;
        push_job.major_is_col = major_is_col;
        push_job.slope        = (phase_neg ^ step_neg) ? -slope_pos : slope_pos;
    end

    // writes off the map are taken and dropped
    assign push_valid = item.valid && ((cmd_t'(item.command) == CMD_CAST) || on_map);
    assign item.ready = push_ready;

endmodule

[design/rchf_queue.sv]
module rchf_queue
    import rchf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    job_t                   slot_reg [QUEUE_DEPTH];
    logic                   push_fire;
    logic                   pop_fire;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[design/rchf_back.sv]
module rchf_back
    import rchf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  job_t          job,
    rchf_result_if.source result
);

    bk_state_t               state_reg;
    bk_state_t               state_next;
    logic                    step_neg_reg;
    logic                    step_neg_next;
    logic                    major_is_col_reg;
    logic                    major_is_col_next;
    logic signed [ACC_W-1:0] slope_reg;
    logic signed [ACC_W-1:0] slope_next;
    logic signed [STEP_W-1:0] a_reg;
    logic signed [STEP_W-1:0] a_next;
    logic signed [ACC_W-1:0] pb_reg;
    logic signed [ACC_W-1:0] pb_next;
    logic signed [ACC_W-1:0] pbn_reg;
    logic signed [ACC_W-1:0] pbn_next;
    logic                    chk_valid_reg;
    logic                    chk_valid_next;
    logic                    chk_cont_reg;
    logic                    chk_cont_next;
    logic signed [POS_W-1:0] chk_x_reg;
    logic signed [POS_W-1:0] chk_x_next;
    logic signed [POS_W-1:0] chk_y_reg;
    logic signed [POS_W-1:0] chk_y_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [COORD_W-1:0]      hit_col_reg;
    logic [COORD_W-1:0]      hit_col_next;
    logic [COORD_W-1:0]      hit_row_reg;
    logic [COORD_W-1:0]      hit_row_next;
    logic                    blocked_reg;
    logic                    blocked_next;

    pix_class_t              pix_mem [MAP_CELLS];
    pix_class_t              rd_a_reg;
    pix_class_t              rd_b_reg;
    logic                    in_a_reg;
    logic                    in_b_reg;
    logic                    mem_we;
    logic [ADDR_W-1:0]       rd_addr_a;
    logic [ADDR_W-1:0]       rd_addr_b;
    logic                    in_a;
    logic                    in_b;

    logic signed [STEP_W-1:0] step_unit;
    logic signed [STEP_W-1:0] a_ahead;
    logic signed [POS_W-1:0] major_pos;
    logic signed [POS_W-1:0] major_pos_n;
    logic signed [POS_W-1:0] lat_pos;
    logic signed [POS_W-1:0] lat_pos_n;
    logic signed [POS_W-1:0] x_cur;
    logic signed [POS_W-1:0] y_cur;
    logic signed [POS_W-1:0] x_nxt;
    logic signed [POS_W-1:0] y_nxt;
    logic                    bound_break;
    logic                    cont;
    pix_class_t              cls_a;
    pix_class_t              cls_b;
    logic                    hit_now;

    // step datapath: positions of the current step and its successor
    always_comb
    begin
        step_unit   = {STEP_W{step_neg_reg}} | STEP_W'(1);
        a_ahead     = a_reg + step_unit;
        cont        = (a_ahead < REACH_S) && (a_ahead > -REACH_S);
        bound_break = (pbn_reg >= ACC_BOUND) || (pbn_reg <= -ACC_BOUND);
        major_pos   = POS_W'(a_reg) + REACH_P;
        major_pos_n = major_pos + POS_W'(step_unit);
        lat_pos     = POS_W'(pb_reg >>> TAN_FRAC_BITS) + REACH_P;
        lat_pos_n   = POS_W'(pbn_reg >>> TAN_FRAC_BITS) + REACH_P;
        if (major_is_col_reg)
        begin
            x_cur = major_pos;
            y_cur = lat_pos;
            x_nxt = major_pos_n;
            y_nxt = lat_pos_n;
        end
        else
        begin
            x_cur = lat_pos;
            y_cur = major_pos;
            x_nxt = lat_pos_n;
            y_nxt = major_pos_n;
        end
        in_a      = (x_cur >= 0) && (int'(x_cur) < MAP_SIDE) &&
                    (y_cur >= 0) && (int'(y_cur) < MAP_SIDE);
        in_b      = (x_nxt >= 0) && (int'(x_nxt) < MAP_SIDE) &&
                    (y_nxt >= 0) && (int'(y_nxt) < MAP_SIDE);
        rd_addr_a = ADDR_W'(y_cur) * ADDR_W'(MAP_SIDE) + ADDR_W'(x_cur);
        rd_addr_b = ADDR_W'(y_nxt) * ADDR_W'(MAP_SIDE) + ADDR_W'(x_nxt);
    end

    assign cls_a   = in_a_reg ? rd_a_reg : PCLS_NONE;
    assign cls_b   = in_b_reg ? rd_b_reg : PCLS_NONE;
    assign hit_now = chk_valid_reg && (cls_a != PCLS_NONE) && (cls_a == cls_b);
    assign mem_we  = (state_reg == BK_IDLE) && job_valid && job_ready &&
                     (job.cmd == CMD_WRITE);

    always_comb
    begin
        state_next        = state_reg;
        step_neg_next     = step_neg_reg;
        major_is_col_next = major_is_col_reg;
        slope_next        = slope_reg;
        a_next            = a_reg;
        pb_next           = pb_reg;
        pbn_next          = pbn_reg;
        chk_valid_next    = chk_valid_reg;
        chk_cont_next     = chk_cont_reg;
        chk_x_next        = chk_x_reg;
        chk_y_next        = chk_y_reg;
        out_valid_next    = out_valid_reg;
        hit_col_next      = hit_col_reg;
        hit_row_next      = hit_row_reg;
        blocked_next      = blocked_reg;
        job_ready         = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                chk_valid_next = 1'b0;
                job_ready      = (job.cmd == CMD_WRITE) || !out_valid_reg;
                if (job_valid && job_ready && (job.cmd == CMD_CAST))
                begin
                    step_neg_next     = job.step_neg;
                    major_is_col_next = job.major_is_col;
                    slope_next        = ACC_W'(job.slope);
                    a_next            = {STEP_W{job.step_neg}} | STEP_W'(1);
                    pb_next           = ACC_W'(job.slope);
                    pbn_next          = ACC_W'(job.slope) <<< 1;
                    state_next        = BK_MARCH;
                end
            end
            BK_MARCH:
            begin
                priority if (hit_now)
                begin
                    state_next     = BK_IDLE;
                    chk_valid_next = 1'b0;
                    out_valid_next = 1'b1;
                    hit_col_next   = COORD_W'(chk_x_reg);
                    hit_row_next   = COORD_W'(chk_y_reg);
                    blocked_next   = 1'b1;
                end
                else if (chk_valid_reg && !chk_cont_reg)
                begin
                    state_next     = BK_IDLE;
                    chk_valid_next = 1'b0;
                    out_valid_next = 1'b1;
                    hit_col_next   = COORD_W'(chk_x_reg);
                    hit_row_next   = COORD_W'(chk_y_reg);
                    blocked_next   = 1'b0;
                end
                else if (bound_break)
                begin
                    state_next     = BK_IDLE;
                    chk_valid_next = 1'b0;
                    out_valid_next = 1'b1;
                    hit_col_next   = chk_valid_reg ? COORD_W'(chk_x_reg) : '0;
                    hit_row_next   = chk_valid_reg ? COORD_W'(chk_y_reg) : '0;
                    blocked_next   = 1'b0;
                end
                else
                begin
                    a_next         = a_ahead;
                    pb_next        = pbn_reg;
                    pbn_next       = pbn_reg + slope_reg;
                    chk_valid_next = 1'b1;
                    chk_cont_next  = cont;
                    chk_x_next     = x_cur;
                    chk_y_next     = y_cur;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_neg_reg     <= step_neg_next;
        major_is_col_reg <= major_is_col_next;
        slope_reg        <= slope_next;
        a_reg            <= a_next;
        pb_reg           <= pb_next;
        pbn_reg          <= pbn_next;
        chk_cont_reg     <= chk_cont_next;
        chk_x_reg        <= chk_x_next;
        chk_y_reg        <= chk_y_next;
        hit_col_reg      <= hit_col_next;
        hit_row_reg      <= hit_row_next;
        blocked_reg      <= blocked_next;
        in_a_reg         <= in_a;
        in_b_reg         <= in_b;
    end

    // map store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pix_mem[job.addr] <= job.pcls;
        end
        rd_a_reg <= pix_mem[rd_addr_a];
        rd_b_reg <= pix_mem[rd_addr_b];
    end

    assign result.valid   = out_valid_reg;
    assign result.hit_col = hit_col_reg;
    assign result.hit_row = hit_row_reg;
    assign result.blocked = blocked_reg;

`ifndef SYNTH
    a_result_from_march: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == BK_MARCH))
        else $error("result raised outside a march");

    a_cast_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready && (job.cmd == CMD_CAST)) |-> !out_valid_reg)
        else $error("cast started while a result is pending");

    a_idle_no_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_IDLE) |-> !chk_valid_reg)
        else $error("check stage busy while idle");

    a_step_in_reach: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_MARCH) |-> ((a_reg <= REACH_S) && (a_reg >= -REACH_S)))
        else $error("march step beyond reach");
`endif

endmodule

[design/ray_cast_color_hit_finder.sv]
// channel   dir  transfer fields
// item      in   command, pixel_col, pixel_row, blue, green, red, angle_deg
// result    out  hit_col, hit_row, blocked (one per cast, none per write)
// cfg       in   index, data (0: block_color_one, 1: block_color_two)
//
// a write leaves the job queue and updates the map store in the same cycle
// a cast marches one step per cycle, reading the pixel of each step and of its successor
// through the two read ports of the map store
// reset restores both colors; the map store is not cleared and must be written
// a two-entry job queue lets item transfers continue while a result waits;
// a cast leaves the queue only once the previous result has been taken
module ray_cast_color_hit_finder
    import rchf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rchf_item_if.sink     item,
    rchf_cfg_if.sink      cfg,
    rchf_result_if.source result
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    rchf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    rchf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    rchf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .result    (result)
    );

endmodule

[tb/ray_cast_color_hit_finder_tb.sv]
`timescale 1ns / 1ps

module ray_cast_color_hit_finder_tb;
    import rchf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 340;
    localparam int TABLE_FRAC    = 16;
    localparam int TABLE_TOP     = TAN_ENTRIES - 1;
    localparam int MAX_REPORTS   = 100;
    localparam longint TIMEOUT_NS = 64'd50_000_000;

    localparam logic [1:0] PLAN_UNSET = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    typedef struct packed {
        cmd_t               command;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [ANGLE_W-1:0] angle;
    } map_op_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               blocked;
    } hit_t;

    logic clk;
    logic rst_n;

    rchf_item_if   item_bus ();
    rchf_cfg_if    cfg_bus ();
    rchf_result_if result_bus ();

    ray_cast_color_hit_finder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .cfg    (cfg_bus),
        .result (result_bus)
    );

    pix_class_t         map_cls [MAP_CELLS];
    logic [1:0]         plan_cls [MAP_CELLS];
    logic [COLOR_W-1:0] color_one;
    logic [COLOR_W-1:0] color_two;

    map_op_t map_ops [$];
    hit_t    due_hits [$];
    int      far_angles [$];
    map_op_t cur_op;
    hit_t    seen_hit;
    hit_t    due_hit;
    int      ops_queued;
    int      fail_count;
    int      send_idle;
    int      recv_stall;

    always #(CLK_HALF) clk = ~clk;

    function automatic pix_class_t classify(input logic [COLOR_W-1:0] rgb);
        if (rgb == color_one)
            return PCLS_ONE;
        if (rgb == color_two)
            return PCLS_TWO;
        return PCLS_NONE;
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color(input int density);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < density / 2)
            return color_one;
        if (roll < density)
            return color_two;
        if ($urandom_range(0, 2) == 0)
            return color_one ^ (COLOR_W'(1) << $urandom_range(0, COLOR_W - 1));
        return COLOR_W'($urandom);
    endfunction

    function automatic void queue_write(input int col, input int row,
                                        input logic [COLOR_W-1:0] rgb);
        map_op_t op;
        op.command = CMD_WRITE;
        op.col     = COORD_W'(col);
        op.row     = COORD_W'(row);
        op.red     = rgb[23:16];
        op.green   = rgb[15:8];
        op.blue    = rgb[7:0];
        op.angle   = ANGLE_W'($urandom);
        map_ops = {map_ops, op};
        ops_queued++;
        if (col < MAP_SIDE && row < MAP_SIDE)
            plan_cls[row * MAP_SIDE + col] = classify(rgb);
    endfunction

    // any map pixel a planned cast will read gets written first
    function automatic void settle_pixel(input int x, input int y, input int density);
        if (x >= 0 && y >= 0 && x < MAP_SIDE && y < MAP_SIDE)
            if (plan_cls[y * MAP_SIDE + x] == PLAN_UNSET)
                queue_write(x, y, pick_color(density));
    endfunction

    function automatic pix_class_t class_at(input int x, input int y, input bit planning);
        if (x < 0 || y < 0 || x >= MAP_SIDE || y >= MAP_SIDE)
            return PCLS_NONE;
        if (planning)
            return pix_class_t'(plan_cls[y * MAP_SIDE + x]);
        return map_cls[y * MAP_SIDE + x];
    endfunction

    function automatic longint tan_slope(input int phase);
        int     idx;
        longint mag;
        idx = (phase < 0) ? -phase : phase;
        if (idx > TABLE_TOP)
            idx = TABLE_TOP;
        mag = longint'(TAN_Q16[idx]);
        if (TAN_FRAC_BITS >= TABLE_FRAC)
            mag = mag << (TAN_FRAC_BITS - TABLE_FRAC);
        else
            mag = mag >> (TABLE_FRAC - TAN_FRAC_BITS);
        return (phase < 0) ? -mag : mag;
    endfunction

    function automatic hit_t trace_ray(input logic [ANGLE_W-1:0] ang, input bit planning,
                                       input int density);
        int         sum;
        int         phase;
        int         quad;
        int         x;
        int         y;
        int         nx;
        int         ny;
        longint     u;
        longint     a;
        longint     an;
        longint     slope;
        longint     pb;
        longint     pbn;
        longint     tb;
        longint     lb;
        longint     lbn;
        bit         col_major;
        bit         blocked;
        pix_class_t here;
        hit_t       res;
        sum       = int'(ang) + ANG_OFFSET;
        phase     = ANG_OFFSET - (sum % ANG_QUARTER);
        quad      = (sum % ANG_FULL) / ANG_QUARTER;
        u         = (quad < 2) ? 1 : -1;
        col_major = (quad == 1 || quad == 3);
        slope     = tan_slope(phase);
        a         = 0;
        an        = 0;
        x         = 0;
        y         = 0;
        blocked   = 1'b0;
        while (an < REACH && an > -REACH)
        begin
            a   = a + u;
            an  = a + u;
            pb  = a * slope;
            pbn = an * slope;
            tb  = (pbn < 0) ? -((-pbn) >>> TAN_FRAC_BITS) : (pbn >>> TAN_FRAC_BITS);
            if (tb > REACH || tb < -REACH)
                break;
            lb  = (pb >>> TAN_FRAC_BITS) + REACH;
            lbn = (pbn >>> TAN_FRAC_BITS) + REACH;
            if (col_major)
            begin
                x  = int'(a) + REACH;
                y  = int'(lb);
                nx = x + int'(u);
                ny = int'(lbn);
            end
            else
            begin
                x  = int'(lb);
                y  = int'(a) + REACH;
                nx = int'(lbn);
                ny = y + int'(u);
            end
            if (planning)
            begin
                settle_pixel(x, y, density);
                settle_pixel(nx, ny, density);
            end
            here = class_at(x, y, planning);
            if (here != PCLS_NONE && here == class_at(nx, ny, planning))
            begin
                blocked = 1'b1;
                break;
            end
        end
        res.col     = COORD_W'(x);
        res.row     = COORD_W'(y);
        res.blocked = blocked;
        return res;
    endfunction

    function automatic void queue_cast(input int ang, input int density);
        map_op_t op;
        void'(trace_ray(ANGLE_W'(ang), 1'b1, density));
        op.command = CMD_CAST;
        op.col     = COORD_W'($urandom);
        op.row     = COORD_W'($urandom);
        op.red     = CHAN_W'($urandom);
        op.green   = CHAN_W'($urandom);
        op.blue    = CHAN_W'($urandom);
        op.angle   = ANGLE_W'(ang);
        map_ops = {map_ops, op};
        ops_queued++;
    endfunction

    task automatic random_batch(input int budget);
        int stop_at;
        int pick;
        int ang;
        stop_at = ops_queued + budget;
        while (ops_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    // long march over mostly neutral pixels
                    if (far_angles.size() == 0 || $urandom_range(0, 9) == 0)
                        far_angles = {far_angles, int'($urandom_range(0, 511))};
                    ang = far_angles[$urandom_range(0, far_angles.size() - 1)];
                    queue_cast(ang, 0);
                end
                else
                begin
                    queue_cast($urandom_range(0, 511), 20 + 30 * $urandom_range(0, 2));
                end
            end
            else if (pick < 85)
            begin
                queue_write(REACH - 24 + $urandom_range(0, 48),
                            REACH - 24 + $urandom_range(0, 48), pick_color(50));
            end
            else
            begin
                queue_write($urandom_range(0, 1023), $urandom_range(0, 1023),
                            pick_color(50));
            end
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (map_ops.size() != 0 || item_bus.valid || due_hits.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic post_config(input logic [CFG_IDX_W-1:0] idx,
                               input logic [COLOR_W-1:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_COLOR_ONE: color_one = value;
            REG_COLOR_TWO: color_two = value;
            default: ;
        endcase
    endtask

    // item driver and predictor update on each transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_bus.valid <= 1'b0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                if (cur_op.command == CMD_CAST)
                    due_hits = {due_hits, trace_ray(cur_op.angle, 1'b0, 0)};
                else if (cur_op.col < MAP_SIDE && cur_op.row < MAP_SIDE)
                    map_cls[int'(cur_op.row) * MAP_SIDE + int'(cur_op.col)] =
                        classify({cur_op.red, cur_op.green, cur_op.blue});
            end
            if (!item_bus.valid || item_bus.ready)
            begin
                if (map_ops.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    cur_op = map_ops.pop_front();
                    item_bus.valid     <= 1'b1;
                    item_bus.command   <= cur_op.command;
                    item_bus.pixel_col <= cur_op.col;
                    item_bus.pixel_row <= cur_op.row;
                    item_bus.blue      <= cur_op.blue;
                    item_bus.green     <= cur_op.green;
                    item_bus.red       <= cur_op.red;
                    item_bus.angle_deg <= cur_op.angle;
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                seen_hit.col     = result_bus.hit_col;
                seen_hit.row     = result_bus.hit_row;
                seen_hit.blocked = result_bus.blocked;
                if (due_hits.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result col=%0d row=%0d blocked=%0b",
                                 $time, seen_hit.col, seen_hit.row, seen_hit.blocked);
                end
                else
                begin
                    due_hit = due_hits.pop_front();
                    if (seen_hit.col !== due_hit.col || seen_hit.row !== due_hit.row ||
                        seen_hit.blocked !== due_hit.blocked)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"%0t: mismatch expected col=%0d row=%0d blocked=%0b",
                                      " got col=%0d row=%0d blocked=%0b"}, $time,
                                     due_hit.col, due_hit.row, due_hit.blocked,
                                     seen_hit.col, seen_hit.row, seen_hit.blocked);
                    end
                end
            end
            result_bus.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int               phase_no;
        int               k;
        int               sweep [12];
        logic [COLOR_W-1:0] rgb;
        sweep = '{0, 45, 90, 135, 180, 225, 270, 315, 359, 360, 405, 511};
        clk                 = 1'b0;
        rst_n               = 1'b0;
        item_bus.valid      = 1'b0;
        item_bus.command    = CMD_WRITE;
        item_bus.pixel_col  = '0;
        item_bus.pixel_row  = '0;
        item_bus.blue       = '0;
        item_bus.green      = '0;
        item_bus.red        = '0;
        item_bus.angle_deg  = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_COLOR_ONE;
        cfg_bus.data        = '0;
        result_bus.ready    = 1'b0;
        color_one           = COLOR_ONE_RESET;
        color_two           = COLOR_TWO_RESET;
        ops_queued          = 0;
        fail_count          = 0;
        send_idle           = 0;
        recv_stall          = 0;
        for (k = 0; k < MAP_CELLS; k++)
        begin
            plan_cls[k] = PLAN_UNSET;
            map_cls[k]  = PCLS_NONE;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            case (phase_no)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    post_config(REG_COLOR_ONE, '0);
                    post_config(REG_COLOR_TWO, '1);
                    send_idle  = 85;
                    recv_stall = 0;
                end
                2:
                begin
                    // both colors equal, spare indexes ignored
                    rgb = COLOR_W'($urandom);
                    post_config(REG_COLOR_ONE, rgb);
                    post_config(REG_COLOR_TWO, rgb);
                    post_config(REG_SPARE_LO, COLOR_W'($urandom));
                    post_config(REG_SPARE_HI, COLOR_W'($urandom));
                    send_idle  = 0;
                    recv_stall = 85;
                end
                3:
                begin
                    post_config(REG_COLOR_ONE, '1);
                    post_config(REG_COLOR_TWO, '0);
                    send_idle  = 20;
                    recv_stall = 20;
                end
                default:
                begin
                    post_config(REG_COLOR_ONE, COLOR_ONE_RESET);
                    post_config(REG_COLOR_TWO, COLOR_W'($urandom));
                    send_idle  = 0;
                    recv_stall = 0;
                end
            endcase
            @(negedge clk);

            if (phase_no == 0)
            begin
                // writes off the map, corner pixels, one ray to the edge, all octants
                queue_write(MAP_SIDE, 0, COLOR_W'($urandom));
                queue_write(0, MAP_SIDE, COLOR_W'($urandom));
                queue_write(1023, 1023, COLOR_W'($urandom));
                queue_write(0, 0, color_one);
                queue_write(MAP_SIDE - 1, MAP_SIDE - 1, color_two);
                far_angles = {far_angles, 90};
                queue_cast(90, 0);
                for (k = 0; k < 12; k++)
                    queue_cast(sweep[k], 80);
            end

            random_batch(PHASE_ITEMS / 2);
            drain();
            random_batch(PHASE_ITEMS / 2);
            drain();
        end

        repeat (REACH + SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && due_hits.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
design/rchf_pkg.sv
design/rchf_ifs.sv
design/rchf_front.sv
design/rchf_queue.sv
design/rchf_back.sv
design/ray_cast_color_hit_finder.sv
tb/ray_cast_color_hit_finder_tb.sv
